/* hw/rtl/rpc_pkg.sv */
// ----------------------------------------------------------------------------
// rpc_pkg: shared types and constants of the rectangle polygon clipper
// Token kinds, the token handshake group and the state encodings used by the
// clip cells, the intercept unit and the top level.
// ----------------------------------------------------------------------------
package rpc_pkg;

    localparam int NUM_STAGES = 4;
    localparam int TOL_WIDTH  = 16;
    localparam int IDX_WIDTH  = 3;

    localparam logic [IDX_WIDTH-1:0] REG_LEFT   = 3'd0;
    localparam logic [IDX_WIDTH-1:0] REG_RIGHT  = 3'd1;
    localparam logic [IDX_WIDTH-1:0] REG_TOP    = 3'd2;
    localparam logic [IDX_WIDTH-1:0] REG_BOTTOM = 3'd3;
    localparam logic [IDX_WIDTH-1:0] REG_TOL    = 3'd4;

    // A vertex token carries a point and closes its item; a point token is a
    // point made inside the chain; the end and finish tokens carry no point.
    typedef enum logic [1:0] {
        K_POINT,
        K_VERTEX,
        K_VEND,
        K_FIN
    } t_kind;

    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_tok;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_CROSS,
        S_EMIT_X,
        S_EMIT_P,
        S_EMIT_T
    } t_cell_state;

    typedef enum logic [1:0] {
        P_IDLE,
        P_MUL,
        P_DIV,
        P_FIX
    } t_ip_state;

endpackage

/* hw/rtl/rpc_interp.sv */
// ----------------------------------------------------------------------------
// rpc_interp: iterative edge intercept unit
// Computes po + (e - pc) * (qo - po) / (qc - pc) with a bit-serial multiply,
// a restoring divide truncating toward zero and saturation of the sum.
// ----------------------------------------------------------------------------
module rpc_interp
    import rpc_pkg::*;
#(
    parameter int W = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [W-1:0] i_e,
    input  logic signed [W-1:0] i_pc,
    input  logic signed [W-1:0] i_po,
    input  logic signed [W-1:0] i_qc,
    input  logic signed [W-1:0] i_qo,
    output logic                o_done,
    output logic signed [W-1:0] o_res
);

    localparam int CW = $clog2(2 * W);
    localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

    function automatic logic [W-1:0] adiff(logic signed [W-1:0] a, logic signed [W-1:0] b);
        adiff = (a < b) ? W'(b - a) : W'(a - b);
    endfunction

    t_ip_state           r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [W-1:0]        r_a, n_a;
    logic [2*W-1:0]      r_b, n_b;
    logic [2*W-1:0]      r_prod, n_prod;
    logic [W-1:0]        r_rem, n_rem;
    logic [2*W-1:0]      r_q, n_q;
    logic [W-1:0]        r_d, n_d;
    logic                r_neg, n_neg;
    logic signed [W-1:0] r_po, n_po;
    logic signed [W-1:0] r_res, n_res;
    logic                r_done, n_done;

    logic [W:0]   trial;
    logic [W-1:0] room;
    logic         sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_cnt  <= n_cnt;
        r_a    <= n_a;
        r_b    <= n_b;
        r_prod <= n_prod;
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_d    <= n_d;
        r_neg  <= n_neg;
        r_po   <= n_po;
        r_res  <= n_res;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_a     = r_a;
        n_b     = r_b;
        n_prod  = r_prod;
        n_rem   = r_rem;
        n_q     = r_q;
        n_d     = r_d;
        n_neg   = r_neg;
        n_po    = r_po;
        n_res   = r_res;
        n_done  = 1'b0;
        trial   = {r_rem, r_prod[2*W-1]};
        room    = r_neg ? W'(r_po - CMIN) : W'(CMAX - r_po);
        sat     = r_q > {{W{1'b0}}, room};
        case (r_state)
            P_IDLE: begin
                if (i_start) begin
                    n_a     = adiff(i_e, i_pc);
                    n_b     = {{W{1'b0}}, adiff(i_qo, i_po)};
                    n_d     = adiff(i_qc, i_pc);
                    n_neg   = ((i_e < i_pc) != (i_qo < i_po)) != (i_qc < i_pc);
                    n_po    = i_po;
                    n_prod  = '0;
                    n_cnt   = '0;
                    n_state = P_MUL;
                end
            end
            P_MUL: begin
                if (r_a[0]) begin
                    n_prod = r_prod + r_b;
                end
                n_b   = {r_b[2*W-2:0], 1'b0};
                n_a   = {1'b0, r_a[W-1:1]};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    n_cnt   = '0;
                    n_rem   = '0;
                    n_q     = '0;
                    n_state = P_DIV;
                end
            end
            P_DIV: begin
                if (trial >= {1'b0, r_d}) begin
                    n_rem = W'(trial - {1'b0, r_d});
                    n_q   = {r_q[2*W-2:0], 1'b1};
                end else begin
                    n_rem = trial[W-1:0];
                    n_q   = {r_q[2*W-2:0], 1'b0};
                end
                n_prod = {r_prod[2*W-2:0], 1'b0};
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CW'(2 * W - 1)) begin
                    n_state = P_FIX;
                end
            end
            P_FIX: begin
                // A zero divisor cannot come from the inside tests; it yields po.
                if (r_d == '0 || r_q == '0) begin
                    n_res = r_po;
                end else if (sat) begin
                    n_res = r_neg ? CMIN : CMAX;
                end else if (r_neg) begin
                    n_res = r_po - $signed(r_q[W-1:0]);
                end else begin
                    n_res = r_po + $signed(r_q[W-1:0]);
                end
                n_done  = 1'b1;
                n_state = P_IDLE;
            end
            default: n_state = P_IDLE;
        endcase
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

/* hw/rtl/rpc_cell.sv */
// ----------------------------------------------------------------------------
// rpc_cell: one clip stage of the chain
// Holds the stage's first and last points, tests each point against its edge
// and hands crossings, inside points and item tokens to the next cell.
// ----------------------------------------------------------------------------
module rpc_cell
    import rpc_pkg::*;
#(
    parameter int W     = 32,
    parameter int STAGE = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic signed [W-1:0]  i_edge,
    input  logic [TOL_WIDTH-1:0] i_tol,
    input  t_tok                 i_up,
    input  logic signed [W-1:0]  i_up_x,
    input  logic signed [W-1:0]  i_up_y,
    output logic                 o_up_ready,
    output t_tok                 o_dn,
    output logic signed [W-1:0]  o_dn_x,
    output logic signed [W-1:0]  o_dn_y,
    input  logic                 i_dn_ready
);

    localparam bit AXIS_X  = (STAGE < 2);
    localparam bit GREATER = ((STAGE % 2) == 0);

    function automatic logic [W-1:0] adiff(logic signed [W-1:0] a, logic signed [W-1:0] b);
        adiff = (a < b) ? W'(b - a) : W'(a - b);
    endfunction

    function automatic logic inside_edge(logic signed [W-1:0] c, logic signed [W-1:0] e,
                                         logic [TOL_WIDTH-1:0] tol);
        logic beyond;
        beyond = GREATER ? (c > e) : (c < e);
        inside_edge = beyond || (adiff(c, e) < W'(tol));
    endfunction

    t_cell_state         r_state, n_state;
    t_kind               r_kind, n_kind;
    logic signed [W-1:0] r_px, n_px, r_py, n_py;
    logic signed [W-1:0] r_lx, n_lx, r_ly, n_ly;
    logic signed [W-1:0] r_fx, n_fx, r_fy, n_fy;
    logic                r_first, n_first;
    logic                r_pin, n_pin;
    t_tok                r_dn, n_dn;
    logic signed [W-1:0] r_dx, n_dx, r_dy, n_dy;

    logic signed [W-1:0] pa, po, la, lo, xres;
    logic                pin, lin, start, done, out_free;

    assign pa  = AXIS_X ? r_px : r_py;
    assign po  = AXIS_X ? r_py : r_px;
    assign la  = AXIS_X ? r_lx : r_ly;
    assign lo  = AXIS_X ? r_ly : r_lx;
    assign pin = inside_edge(pa, i_edge, i_tol);
    assign lin = inside_edge(la, i_edge, i_tol);
    assign out_free = !r_dn.valid || i_dn_ready;

    rpc_interp #(.W(W)) u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_e     (i_edge),
        .i_pc    (pa),
        .i_po    (po),
        .i_qc    (la),
        .i_qo    (lo),
        .o_done  (done),
        .o_res   (xres)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_first    <= 1'b1;
            r_dn.valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_first    <= n_first;
            r_dn.valid <= n_dn.valid;
        end
        r_dn.kind <= n_dn.kind;
        r_kind    <= n_kind;
        r_px      <= n_px;
        r_py      <= n_py;
        r_lx      <= n_lx;
        r_ly      <= n_ly;
        r_fx      <= n_fx;
        r_fy      <= n_fy;
        r_pin     <= n_pin;
        r_dx      <= n_dx;
        r_dy      <= n_dy;
    end

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_px    = r_px;
        n_py    = r_py;
        n_lx    = r_lx;
        n_ly    = r_ly;
        n_fx    = r_fx;
        n_fy    = r_fy;
        n_first = r_first;
        n_pin   = r_pin;
        n_dn    = r_dn;
        n_dx    = r_dx;
        n_dy    = r_dy;
        start   = 1'b0;
        if (r_dn.valid && i_dn_ready) begin
            n_dn.valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_up.valid) begin
                    n_kind = i_up.kind;
                    // A finish closes the stage with its own first point.
                    if (i_up.kind == K_FIN) begin
                        n_px = r_fx;
                        n_py = r_fy;
                    end else begin
                        n_px = i_up_x;
                        n_py = i_up_y;
                    end
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_kind == K_VEND) begin
                    n_state = S_EMIT_T;
                end else if (r_first) begin
                    n_fx    = r_px;
                    n_fy    = r_py;
                    n_first = 1'b0;
                    n_lx    = r_px;
                    n_ly    = r_py;
                    n_state = (r_kind == K_POINT) ? S_IDLE : S_EMIT_T;
                end else begin
                    n_pin = pin;
                    if (pin != lin) begin
                        start   = 1'b1;
                        n_state = S_CROSS;
                    end else if (pin) begin
                        n_state = S_EMIT_P;
                    end else begin
                        n_lx    = r_px;
                        n_ly    = r_py;
                        n_state = (r_kind == K_POINT) ? S_IDLE : S_EMIT_T;
                    end
                end
            end
            S_CROSS: begin
                if (done) begin
                    n_state = S_EMIT_X;
                end
            end
            S_EMIT_X: begin
                if (out_free) begin
                    n_dn.valid = 1'b1;
                    n_dn.kind  = K_POINT;
                    n_dx       = AXIS_X ? i_edge : xres;
                    n_dy       = AXIS_X ? xres : i_edge;
                    if (r_pin) begin
                        n_state = S_EMIT_P;
                    end else begin
                        n_lx    = r_px;
                        n_ly    = r_py;
                        n_state = (r_kind == K_POINT) ? S_IDLE : S_EMIT_T;
                    end
                end
            end
            S_EMIT_P: begin
                if (out_free) begin
                    n_dn.valid = 1'b1;
                    n_dn.kind  = K_POINT;
                    n_dx       = r_px;
                    n_dy       = r_py;
                    n_lx       = r_px;
                    n_ly       = r_py;
                    n_state    = (r_kind == K_POINT) ? S_IDLE : S_EMIT_T;
                end
            end
            S_EMIT_T: begin
                if (out_free) begin
                    n_dn.valid = 1'b1;
                    n_dn.kind  = (r_kind == K_FIN) ? K_FIN : K_VEND;
                    if (r_kind == K_FIN) begin
                        n_first = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_up_ready = (r_state == S_IDLE);
    assign o_dn       = r_dn;
    assign o_dn_x     = r_dx;
    assign o_dn_y     = r_dy;

endmodule

/* hw/rtl/rpc_writer.sv */
// ----------------------------------------------------------------------------
// rpc_writer: duplicate removal and result framing
// Drops points within the tolerance of the last written point, holds one
// point back so that the last result of an item can carry its marks.
// ----------------------------------------------------------------------------
module rpc_writer
    import rpc_pkg::*;
#(
    parameter int W = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [TOL_WIDTH-1:0] i_tol,
    input  t_tok                 i_up,
    input  logic signed [W-1:0]  i_up_x,
    input  logic signed [W-1:0]  i_up_y,
    output logic                 o_up_ready,
    output logic                 o_valid,
    output logic signed [W-1:0]  o_x,
    output logic signed [W-1:0]  o_y,
    output logic                 o_pv,
    output logic                 o_last,
    output logic                 o_end,
    input  logic                 i_ready
);

    function automatic logic [W-1:0] adiff(logic signed [W-1:0] a, logic signed [W-1:0] b);
        adiff = (a < b) ? W'(b - a) : W'(a - b);
    endfunction

    logic                r_ov, n_ov;
    logic signed [W-1:0] r_ox, n_ox, r_oy, n_oy;
    logic                r_opv, n_opv, r_olast, n_olast, r_oend, n_oend;
    logic                r_pend, n_pend;
    logic signed [W-1:0] r_px, n_px, r_py, n_py;
    logic signed [W-1:0] r_ex, n_ex, r_ey, n_ey;
    logic                r_enone, n_enone;
    logic                out_free, keep;

    assign out_free = !r_ov || i_ready;
    assign keep = r_enone || (adiff(i_up_x, r_ex) > W'(i_tol)) ||
                  (adiff(i_up_y, r_ey) > W'(i_tol));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov    <= 1'b0;
            r_pend  <= 1'b0;
            r_enone <= 1'b1;
        end else begin
            r_ov    <= n_ov;
            r_pend  <= n_pend;
            r_enone <= n_enone;
        end
        r_ox    <= n_ox;
        r_oy    <= n_oy;
        r_opv   <= n_opv;
        r_olast <= n_olast;
        r_oend  <= n_oend;
        r_px    <= n_px;
        r_py    <= n_py;
        r_ex    <= n_ex;
        r_ey    <= n_ey;
    end

    always_comb begin
        n_ov    = r_ov;
        n_ox    = r_ox;
        n_oy    = r_oy;
        n_opv   = r_opv;
        n_olast = r_olast;
        n_oend  = r_oend;
        n_pend  = r_pend;
        n_px    = r_px;
        n_py    = r_py;
        n_ex    = r_ex;
        n_ey    = r_ey;
        n_enone = r_enone;
        if (r_ov && i_ready) begin
            n_ov = 1'b0;
        end
        if (i_up.valid && out_free) begin
            case (i_up.kind)
                K_POINT: begin
                    if (keep) begin
                        if (r_pend) begin
                            n_ov    = 1'b1;
                            n_ox    = r_px;
                            n_oy    = r_py;
                            n_opv   = 1'b1;
                            n_olast = 1'b0;
                            n_oend  = 1'b0;
                        end
                        n_pend  = 1'b1;
                        n_px    = i_up_x;
                        n_py    = i_up_y;
                        n_ex    = i_up_x;
                        n_ey    = i_up_y;
                        n_enone = 1'b0;
                    end
                end
                K_VEND, K_VERTEX: begin
                    if (r_pend) begin
                        n_ov    = 1'b1;
                        n_ox    = r_px;
                        n_oy    = r_py;
                        n_opv   = 1'b1;
                        n_olast = 1'b1;
                        n_oend  = 1'b0;
                    end
                    n_pend = 1'b0;
                end
                K_FIN: begin
                    // A polygon that wrote nothing still ends with an empty word.
                    n_ov    = 1'b1;
                    n_ox    = r_pend ? r_px : '0;
                    n_oy    = r_pend ? r_py : '0;
                    n_opv   = r_pend;
                    n_olast = 1'b1;
                    n_oend  = 1'b1;
                    n_pend  = 1'b0;
                    n_enone = 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_up_ready = out_free;
    assign o_valid    = r_ov;
    assign o_x        = r_ox;
    assign o_y        = r_oy;
    assign o_pv       = r_opv;
    assign o_last     = r_olast;
    assign o_end      = r_oend;

endmodule

/* hw/rtl/rect_polygon_clipper.sv */
// ----------------------------------------------------------------------------
// rect_polygon_clipper: polygon clipping against an axis-aligned rectangle
// Four clip cells (left, right, top, bottom) in a chain, then a writer that
// removes near-duplicate points and frames the results of each item.
//
//  channel  direction  signals                        word
//  s        in         i_s_tvalid/o_s_tready          vertex or finish
//  m        out        o_m_tvalid/i_m_tready          clipped point
//  cfg      in         i_cfg_valid/o_cfg_ready        register write
//
// A cell takes a word while idle, tests it against its edge, runs the
// intercept unit's bit-serial multiply and divide for a crossing, and then
// passes on the crossing, the inside point and the word that closes an item.
// Each cell works on one word at a time; words queue one deep between cells.
// Reset is synchronous and needs no clearing pass. A stalled output holds
// the chain back cell by cell.
// ----------------------------------------------------------------------------
module rect_polygon_clipper
    import rpc_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    localparam int DW = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [DW-1:0]          i_s_tdata,   // vertex_x, vertex_y
    input  logic                   i_s_tuser,   // mode
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [DW-1:0]          o_m_tdata,   // out_x, out_y
    output logic                   o_m_tlast,
    output logic [1:0]             o_m_tuser,   // point_valid, polygon_end
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [IDX_WIDTH-1:0]   i_cfg_index,
    input  logic [COORD_WIDTH-1:0] i_cfg_data
);

    localparam int W = COORD_WIDTH;

    logic signed [W-1:0]  r_edge [NUM_STAGES];
    logic [TOL_WIDTH-1:0] r_tol;

    t_tok                w_tok [NUM_STAGES+1];
    logic signed [W-1:0] w_x   [NUM_STAGES+1];
    logic signed [W-1:0] w_y   [NUM_STAGES+1];
    logic                w_rdy [NUM_STAGES+1];

    logic signed [W-1:0] out_x, out_y;
    logic                out_pv, out_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_STAGES; i++) begin
                r_edge[i] <= '0;
            end
            r_tol <= TOL_WIDTH'(1);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_TOL) begin
                r_tol <= i_cfg_data[TOL_WIDTH-1:0];
            end else if (i_cfg_index == REG_LEFT || i_cfg_index == REG_RIGHT ||
                         i_cfg_index == REG_TOP || i_cfg_index == REG_BOTTOM) begin
                r_edge[i_cfg_index[1:0]] <= i_cfg_data;
            end
        end
    end

    assign o_cfg_ready = 1'b1;

    assign w_tok[0].valid = i_s_tvalid;
    assign w_tok[0].kind  = i_s_tuser ? K_FIN : K_VERTEX;
    assign w_x[0]         = i_s_tdata[W-1:0];
    assign w_y[0]         = i_s_tdata[2*W-1:W];
    assign o_s_tready     = w_rdy[0];

    for (genvar s = 0; s < NUM_STAGES; s++) begin : g_cell
        rpc_cell #(.W(W), .STAGE(s)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_edge     (r_edge[s]),
            .i_tol      (r_tol),
            .i_up       (w_tok[s]),
            .i_up_x     (w_x[s]),
            .i_up_y     (w_y[s]),
            .o_up_ready (w_rdy[s]),
            .o_dn       (w_tok[s+1]),
            .o_dn_x     (w_x[s+1]),
            .o_dn_y     (w_y[s+1]),
            .i_dn_ready (w_rdy[s+1])
        );
    end

    rpc_writer #(.W(W)) u_writer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tol      (r_tol),
        .i_up       (w_tok[NUM_STAGES]),
        .i_up_x     (w_x[NUM_STAGES]),
        .i_up_y     (w_y[NUM_STAGES]),
        .o_up_ready (w_rdy[NUM_STAGES]),
        .o_valid    (o_m_tvalid),
        .o_x        (out_x),
        .o_y        (out_y),
        .o_pv       (out_pv),
        .o_last     (o_m_tlast),
        .o_end      (out_end),
        .i_ready    (i_m_tready)
    );

    assign o_m_tdata = DW'({out_y, out_x});
    assign o_m_tuser = {out_end, out_pv};

`ifndef SYNTH
    // The end of a polygon is always the last word of its finish item.
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |-> o_m_tlast)
        else $error("polygon end without last mark");

    // An empty word only terminates a polygon and carries a zero point.
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tuser[1] && o_m_tdata == '0)
        else $error("empty word outside a polygon end");

    // The first cell works on an accepted word before it takes another.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken twice in a row");
`endif

endmodule

/* tb/sv/rect_polygon_clipper_test.sv */
// ----------------------------------------------------------------------------
// rect_polygon_clipper_test: self-checking bench for the rectangle clipper
// Vertices and finish words go in over the stream slave port with random
// gaps, and the clipped points are taken with random stalls. A scoreboard
// class computes the expected points of every accepted word and compares
// each outgoing word with the oldest expected one. The clip rectangle and
// the tolerance are changed between phases, including extreme settings.
// ----------------------------------------------------------------------------
module rect_polygon_clipper_test;
    import rpc_pkg::*;

    localparam logic MODE_VERTEX = 1'b0;
    localparam logic MODE_FINISH = 1'b1;
    localparam longint CMAX = 64'sd2147483647;
    localparam longint CMIN = -64'sd2147483648;
    localparam int LIMIT_CYCLES = 6000000;
    localparam int ITEM_TARGET = 460;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic        valid;
        logic        last;
        logic        pend;
    } t_clip_point;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata = '0;
    logic        i_s_tuser = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [63:0] o_m_tdata;
    logic        o_m_tlast;
    logic [1:0]  o_m_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [IDX_WIDTH-1:0] i_cfg_index = REG_LEFT;
    logic [31:0] i_cfg_data = '0;

    int errors = 0;
    int words_in = 0;
    int words_out = 0;
    int finishes = 0;
    int cycles = 0;
    int rx_wait = 0;
    bit rx_calm = 1'b0;
    bit tx_calm = 1'b0;

    rect_polygon_clipper dut (.*);

    always #10 i_clk = ~i_clk;

    task automatic report(input string what);
        errors++;
        $display("mismatch at cycle %0d: %s", cycles, what);
    endtask

    // Computes the clipped points of each accepted word and holds them
    // until they leave the block.
    class t_clip_book;
        longint edge_pos[4];
        longint tol;
        longint last_x[4], last_y[4], first_x[4], first_y[4];
        bit     is_first[4];
        longint wr_x, wr_y;
        bit     wr_none;
        t_clip_point pending_points[$];
        int     made;

        function new();
            edge_pos = '{0, 0, 0, 0};
            tol = 1;
            clear();
        endfunction

        function void clear();
            for (int s = 0; s < 4; s++) begin
                last_x[s] = 0; last_y[s] = 0;
                first_x[s] = 0; first_y[s] = 0;
                is_first[s] = 1'b1;
            end
            wr_x = 0; wr_y = 0; wr_none = 1'b1;
        endfunction

        function void set_reg(logic [IDX_WIDTH-1:0] idx, logic [31:0] val);
            longint v;
            v = $signed(val);
            if (idx == REG_TOL) tol = val[15:0];
            else edge_pos[idx[1:0]] = v;
        endfunction

        function longint mag(longint d);
            return (d < 0) ? -d : d;
        endfunction

        function void put(longint x, longint y, bit v);
            t_clip_point p;
            if (made >= 31) return;
            p.x = x[31:0]; p.y = y[31:0]; p.valid = v; p.last = 0; p.pend = 0;
            pending_points.push_back(p);
            made++;
        endfunction

        function void write_pt(longint x, longint y);
            if (wr_none || mag(x - wr_x) > tol || mag(y - wr_y) > tol) begin
                put(x, y, 1'b1);
                wr_x = x; wr_y = y; wr_none = 1'b0;
            end
        endfunction

        // Intercept along the other axis, with the sum saturated.
        function longint intercept(longint e, longint pc, longint po, longint qc,
                                   longint qo);
            logic [63:0] a, b, d, q;
            bit neg;
            longint room;
            a = mag(e - pc); b = mag(qo - po); d = mag(qc - pc);
            if (a == 0 || b == 0 || d == 0) return po;
            q = (a * b) / d;
            neg = ((e < pc) != (qo < po)) != (qc < pc);
            if (q == 0) return po;
            if (!neg) begin
                room = CMAX - po;
                return (q > room) ? CMAX : po + longint'(q);
            end
            room = po - CMIN;
            return (q > room) ? CMIN : po - longint'(q);
        endfunction

        function bit is_inside(int s, longint x, longint y);
            longint e;
            e = edge_pos[s];
            case (s)
                0: return x > e || mag(x - e) < tol;
                1: return x < e || mag(x - e) < tol;
                2: return y > e || mag(y - e) < tol;
                default: return y < e || mag(y - e) < tol;
            endcase
        endfunction

        function void pass_on(int s, longint x, longint y);
            if (s >= 3) write_pt(x, y);
            else stage(s + 1, x, y);
        endfunction

        function void stage(int s, longint x, longint y);
            longint lx, ly, e;
            bit pin, lin;
            lx = last_x[s]; ly = last_y[s]; e = edge_pos[s];
            if (is_first[s]) begin
                first_x[s] = x; first_y[s] = y; is_first[s] = 1'b0;
            end else begin
                pin = is_inside(s, x, y);
                lin = is_inside(s, lx, ly);
                if (pin != lin) begin
                    if (s < 2) pass_on(s, e, intercept(e, x, y, lx, ly));
                    else pass_on(s, intercept(e, y, x, ly, lx), e);
                end
                if (pin) pass_on(s, x, y);
            end
            last_x[s] = x; last_y[s] = y;
        endfunction

        function void take_word(logic mode, logic [31:0] vx, logic [31:0] vy);
            int start;
            longint x, y;
            start = pending_points.size();
            made = 0;
            x = $signed(vx); y = $signed(vy);
            if (mode == MODE_VERTEX) begin
                stage(0, x, y);
                if (pending_points.size() > start)
                    pending_points[pending_points.size()-1].last = 1'b1;
                return;
            end
            for (int s = 0; s < 4; s++) stage(s, first_x[s], first_y[s]);
            if (made == 0) put(0, 0, 1'b0);
            pending_points[pending_points.size()-1].last = 1'b1;
            pending_points[pending_points.size()-1].pend = 1'b1;
            clear();
        endfunction

        task match_word(t_clip_point got);
            t_clip_point want;
            if (pending_points.size() == 0) begin
                report($sformatf("unexpected word x=%h y=%h", got.x, got.y));
                return;
            end
            want = pending_points.pop_front();
            if (got.x !== want.x) report($sformatf("out_x %h, want %h", got.x, want.x));
            if (got.y !== want.y) report($sformatf("out_y %h, want %h", got.y, want.y));
            if (got.valid !== want.valid)
                report($sformatf("point_valid %b, want %b", got.valid, want.valid));
            if (got.last !== want.last)
                report($sformatf("run_last %b, want %b", got.last, want.last));
            if (got.pend !== want.pend)
                report($sformatf("polygon_end %b, want %b", got.pend, want.pend));
        endtask
    endclass

    t_clip_book book = new();

    always @(posedge i_clk) begin
        t_clip_point got;
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("rect_polygon_clipper_test NOT OK");
            $finish;
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready) book.set_reg(i_cfg_index, i_cfg_data);
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            book.take_word(i_s_tuser, i_s_tdata[31:0], i_s_tdata[63:32]);
            words_in++;
            if (i_s_tuser == MODE_FINISH) finishes++;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.x = o_m_tdata[31:0]; got.y = o_m_tdata[63:32];
            got.valid = o_m_tuser[0]; got.last = o_m_tlast; got.pend = o_m_tuser[1];
            book.match_word(got);
            words_out++;
            rx_wait = rx_calm ? 0 : $urandom_range(0, 7);
        end
    end

    always @(negedge i_clk) begin
        if (rx_wait > 0) begin
            i_m_tready <= 1'b0;
            rx_wait--;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [IDX_WIDTH-1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_rect(input longint l, input longint r, input longint t,
                            input longint b, input int tl);
        write_reg(REG_LEFT, l[31:0]);
        write_reg(REG_RIGHT, r[31:0]);
        write_reg(REG_TOP, t[31:0]);
        write_reg(REG_BOTTOM, b[31:0]);
        write_reg(REG_TOL, tl[31:0]);
    endtask

    task automatic send_word(input logic mode, input longint x, input longint y);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 7);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= mode;
        i_s_tdata <= {y[31:0], x[31:0]};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic send_vertex(input longint x, input longint y);
        send_word(MODE_VERTEX, x, y);
    endtask

    task automatic send_finish();
        send_word(MODE_FINISH, $urandom(), $urandom());
    endtask

    // The last word of every phase is a finish, so an empty queue means idle.
    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (book.pending_points.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
    endtask

    function automatic longint clamp(longint v);
        return (v > CMAX) ? CMAX : (v < CMIN) ? CMIN : v;
    endfunction

    // A coordinate around the span lo..hi, sometimes on an edge or just off it.
    function automatic longint near(longint lo, longint hi, int tl);
        longint span, r;
        int pick;
        span = (hi > lo) ? hi - lo : lo - hi;
        if (span < 16) span = 16;
        pick = $urandom_range(0, 9);
        if (pick == 0) return clamp(lo + $signed($urandom_range(0, 4)) - 2);
        if (pick == 1) return clamp(hi + $signed($urandom_range(0, 2 * tl + 2)) - tl - 1);
        if (pick == 2) return $signed($urandom());
        r = {$urandom(), $urandom()};
        if (r < 0) r = -r;
        r = r % (2 * span + 1);
        return clamp(((lo < hi) ? lo : hi) - span / 2 + r);
    endfunction

    task automatic random_phase(input longint l, input longint r, input longint t,
                                input longint b, input int tl, input int count);
        int n, sent;
        set_rect(l, r, t, b, tl);
        sent = 0;
        while (sent < count) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            n = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 8);
            repeat (n) send_vertex(near(l, r, tl), near(t, b, tl));
            send_finish();
            sent += n + 1;
        end
        drain();
    endtask

    initial begin
        longint u;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty finish, a diamond over every edge of the rectangle, a
        // polygon wholly outside, saturating extremes, near duplicates and a lone vertex.
        u = 64'sd65536;
        set_rect(-4 * u, 4 * u, -4 * u, 4 * u, 1);
        send_finish();
        send_vertex(-8 * u, 0); send_vertex(0, 8 * u);
        send_vertex(8 * u, 0); send_vertex(0, -8 * u); send_finish();
        send_vertex(20 * u, 20 * u); send_vertex(30 * u, 20 * u);
        send_vertex(30 * u, 30 * u); send_finish();
        send_vertex(CMIN, CMIN); send_vertex(CMAX, CMIN);
        send_vertex(CMAX, CMAX); send_vertex(CMIN, CMAX); send_finish();
        send_vertex(0, 0); send_vertex(1, 0); send_vertex(0, 1);
        send_vertex(4 * u, 4 * u); send_vertex(4 * u + 1, 4 * u - 1); send_finish();
        send_vertex(u, u); send_finish();
        drain();

        random_phase(CMIN, CMAX, CMIN, CMAX, 0, 40);
        random_phase(-4 * u, 4 * u, -3 * u, 3 * u, 65535, 40);
        random_phase(5 * u, -5 * u, 2 * u, -2 * u, 3, 30);
        random_phase(0, 0, 0, 0, 0, 20);
        while (words_in < ITEM_TARGET - 40) begin
            if ($urandom_range(0, 2) == 0)
                random_phase($signed($urandom()), $signed($urandom()),
                             $signed($urandom()), $signed($urandom()),
                             $urandom_range(0, 65535), 40);
            else
                random_phase(-$signed($urandom_range(0, 1 << 22)),
                             $urandom_range(0, 1 << 22),
                             -$signed($urandom_range(0, 1 << 22)),
                             $urandom_range(0, 1 << 22), $urandom_range(0, 16), 40);
        end

        while (book.pending_points.size() != 0) begin
            report("expected word never came");
            void'(book.pending_points.pop_front());
        end
        $display("sent %0d words (%0d finishes), checked %0d clipped words",
                 words_in, finishes, words_out);
        $display("rectangles included full range, inverted, zero size and random edges");
        if (errors == 0) begin
            $display("rect_polygon_clipper_test OK");
        end else begin
            $display("rect_polygon_clipper_test NOT OK");
        end
        $finish;
    end

endmodule
